>>> design/packet_fifo_dedup_range_count_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet FIFO dedup / range count unit
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef PACKET_FIFO_DEDUP_RANGE_COUNT_UNIT_MACROS_SVH
`define PACKET_FIFO_DEDUP_RANGE_COUNT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> design/pfdrc_pkg.sv
// ----------------------------------------------------------------------------
// pfdrc_pkg
// Shared types and constants of the packet FIFO dedup / range count unit.
// ----------------------------------------------------------------------------
package pfdrc_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int NODE_BITS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int KIND_W  = 2;
   localparam int CAP_W   = 7;
   localparam int COUNT_W = 7;

   localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FWD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CNT = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

endpackage

>>> design/pfdrc_if.sv
// ----------------------------------------------------------------------------
// pfdrc request / response channels
// Valid-ready channels carrying one request and one response item.
// ----------------------------------------------------------------------------
interface pfdrc_req_if #(
   parameter int NODE_BITS = pfdrc_pkg::NODE_BITS_DEFAULT,
   parameter int TIME_BITS = pfdrc_pkg::TIME_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [pfdrc_pkg::KIND_W-1:0]  kind;
   logic [NODE_BITS-1:0]          pkt_source;
   logic [NODE_BITS-1:0]          destination;
   logic [TIME_BITS-1:0]          timestamp;
   logic [TIME_BITS-1:0]          range_low;
   logic [TIME_BITS-1:0]          range_high;

   modport source (output valid, kind, pkt_source, destination, timestamp, range_low,
                   range_high, input ready);
   modport sink   (input valid, kind, pkt_source, destination, timestamp, range_low,
                   range_high, output ready);
endinterface

interface pfdrc_rsp_if #(
   parameter int NODE_BITS = pfdrc_pkg::NODE_BITS_DEFAULT,
   parameter int TIME_BITS = pfdrc_pkg::TIME_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic                          packet_valid;
   logic [NODE_BITS-1:0]          out_source;
   logic [NODE_BITS-1:0]          out_destination;
   logic [TIME_BITS-1:0]          out_timestamp;
   logic [pfdrc_pkg::COUNT_W-1:0] match_count;

   modport source (output valid, accepted, packet_valid, out_source, out_destination,
                   out_timestamp, match_count, input ready);
   modport sink   (input valid, accepted, packet_valid, out_source, out_destination,
                   out_timestamp, match_count, output ready);
endinterface

>>> design/packet_fifo_dedup_range_count_unit.sv
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count_unit
// Bounded packet FIFO with duplicate rejection and destination/time counting.
// ----------------------------------------------------------------------------
// Add and count scan every stored entry through the single entry-memory read
// port, one entry per cycle, in state scan; the unit then passes drain and
// commit, where the response is registered. Forward reads only the head entry;
// forward, add or count on an empty FIFO and kind 3 go from idle to commit.
// Requests are taken only in idle. A response left waiting holds the unit in commit.
// Synchronous reset empties the FIFO and sets capacity to 64; memory not cleared.
`include "packet_fifo_dedup_range_count_unit_macros.svh"

module packet_fifo_dedup_range_count_unit #(
   parameter int DEPTH     = pfdrc_pkg::DEPTH_DEFAULT,
   parameter int NODE_BITS = pfdrc_pkg::NODE_BITS_DEFAULT,
   parameter int TIME_BITS = pfdrc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   pfdrc_req_if.sink                         req_chan,
   pfdrc_rsp_if.source                       rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pfdrc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pfdrc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pfdrc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int OCC_W   = $clog2(DEPTH + 1);
   localparam int CW      = (OCC_W > pfdrc_pkg::CAP_W) ? OCC_W : pfdrc_pkg::CAP_W;
   localparam int ENTRY_W = 2 * NODE_BITS + TIME_BITS;

   // control state
   pfdrc_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [pfdrc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]  cnt_ff, cnt_in;
   logic [OCC_W-1:0]  scan_len_ff, scan_len_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              dup_ff, dup_in;
   logic [pfdrc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request payload
   logic [pfdrc_pkg::KIND_W-1:0] kind_ff;
   logic [NODE_BITS-1:0] src_ff, dst_ff;
   logic [TIME_BITS-1:0] ts_ff, lo_ff, hi_ff;

   // response payload
   logic                 rsp_acc_ff, rsp_acc_in;
   logic                 rsp_pv_ff, rsp_pv_in;
   logic [NODE_BITS-1:0] rsp_src_ff, rsp_src_in;
   logic [NODE_BITS-1:0] rsp_dst_ff, rsp_dst_in;
   logic [TIME_BITS-1:0] rsp_ts_ff, rsp_ts_in;
   logic [pfdrc_pkg::COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // entry memory
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_en;
   logic               wr_en;

   logic req_fire;
   logic commit_fire;
   logic scan_last;
   logic is_add, is_fwd, is_cnt;
   logic no_dup;
   logic fwd_hit;
   logic full;
   logic [CW-1:0] cap_ext, eff_cap;
   logic [NODE_BITS-1:0] e_src, e_dst;
   logic [TIME_BITS-1:0] e_ts;
   logic hit_dup, hit_cnt;
   logic csr_wr;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign req_chan.ready = (state_ff == pfdrc_pkg::ST_IDLE);
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign commit_fire = (state_ff == pfdrc_pkg::ST_COMMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign scan_last   = (cnt_ff == scan_len_ff - OCC_W'(1));
   assign is_add      = (kind_ff == pfdrc_pkg::KIND_ADD);
   assign is_fwd      = (kind_ff == pfdrc_pkg::KIND_FWD);
   assign is_cnt      = (kind_ff == pfdrc_pkg::KIND_CNT);
   assign no_dup      = is_add && !dup_ff;
   assign fwd_hit     = is_fwd && (occ_ff != '0);

   assign cap_ext = CW'(cap_ff);
   assign eff_cap = (cap_ff == '0) ? CW'(1) :
                    ((cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext);
   assign full    = (CW'(occ_ff) >= eff_cap);

   // shared compare unit on the entry just read
   assign {e_src, e_dst, e_ts} = rd_data_ff;
   assign hit_dup = (e_src == src_ff) && (e_dst == dst_ff) && (e_ts == ts_ff);
   assign hit_cnt = (e_dst == dst_ff) && (e_ts >= lo_ff) && (e_ts <= hi_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfdrc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (scan_len_in == '0) ? pfdrc_pkg::ST_COMMIT : pfdrc_pkg::ST_SCAN;
            end
         end
         pfdrc_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = pfdrc_pkg::ST_DRAIN;
            end
         end
         pfdrc_pkg::ST_DRAIN: begin
            state_in = pfdrc_pkg::ST_COMMIT;
         end
         pfdrc_pkg::ST_COMMIT: begin
            if (commit_fire) begin
               state_in = pfdrc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfdrc_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      rd_en          = (state_ff == pfdrc_pkg::ST_SCAN);
      wr_en          = commit_fire && no_dup;
      cmp_valid_in   = rd_en;
      rd_ptr_in      = rd_ptr_ff;
      cnt_in         = cnt_ff;
      scan_len_in    = scan_len_ff;
      dup_in         = dup_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_acc_in     = rsp_acc_ff;
      rsp_pv_in      = rsp_pv_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_dst_in     = rsp_dst_ff;
      rsp_ts_in      = rsp_ts_ff;
      rsp_cnt_in     = rsp_cnt_ff;

      if (req_fire) begin
         rd_ptr_in = head_ff;
         cnt_in    = '0;
         dup_in    = 1'b0;
         count_in  = '0;
         case (req_chan.kind)
            pfdrc_pkg::KIND_ADD: scan_len_in = occ_ff;
            pfdrc_pkg::KIND_CNT: scan_len_in = occ_ff;
            pfdrc_pkg::KIND_FWD: scan_len_in = (occ_ff != '0) ? OCC_W'(1) : '0;
            default:             scan_len_in = '0;
         endcase
      end

      if (rd_en) begin
         rd_ptr_in = next_slot(rd_ptr_ff);
         cnt_in    = cnt_ff + OCC_W'(1);
      end

      if (cmp_valid_ff) begin
         dup_in = dup_ff || hit_dup;
         if (hit_cnt) begin
            count_in = count_ff + pfdrc_pkg::COUNT_W'(1);
         end
      end

      if (commit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in   = no_dup;
         rsp_pv_in    = fwd_hit;
         rsp_src_in   = fwd_hit ? e_src : '0;
         rsp_dst_in   = fwd_hit ? e_dst : '0;
         rsp_ts_in    = fwd_hit ? e_ts : '0;
         rsp_cnt_in   = is_cnt ? count_ff : '0;
         if (no_dup) begin
            tail_in = next_slot(tail_ff);
            if (full) begin
               head_in = next_slot(head_ff);
            end else begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
         if (fwd_hit) begin
            head_in = next_slot(head_ff);
            occ_in  = occ_ff - OCC_W'(1);
         end
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[pfdrc_pkg::CSR_ADDR_W-1:2] == pfdrc_pkg::CSR_IDX_CAPACITY);
   assign cap_in     = csr_wr ? csr_pwdata[pfdrc_pkg::CAP_W-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr[pfdrc_pkg::CSR_ADDR_W-1:2] == pfdrc_pkg::CSR_IDX_CAPACITY) ?
                       pfdrc_pkg::CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfdrc_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         cap_ff       <= pfdrc_pkg::CAP_RESET;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         scan_len_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         dup_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
         scan_len_ff  <= scan_len_in;
         cmp_valid_ff <= cmp_valid_in;
         dup_ff       <= dup_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_chan.kind;
         src_ff  <= req_chan.pkt_source;
         dst_ff  <= req_chan.destination;
         ts_ff   <= req_chan.timestamp;
         lo_ff   <= req_chan.range_low;
         hi_ff   <= req_chan.range_high;
      end
      rsp_acc_ff <= rsp_acc_in;
      rsp_pv_ff  <= rsp_pv_in;
      rsp_src_ff <= rsp_src_in;
      rsp_dst_ff <= rsp_dst_in;
      rsp_ts_ff  <= rsp_ts_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= {src_ff, dst_ff, ts_ff};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.accepted        = rsp_acc_ff;
   assign rsp_chan.packet_valid    = rsp_pv_ff;
   assign rsp_chan.out_source      = rsp_src_ff;
   assign rsp_chan.out_destination = rsp_dst_ff;
   assign rsp_chan.out_timestamp   = rsp_ts_ff;
   assign rsp_chan.match_count     = rsp_cnt_ff;

   `ASSERT_IMPLIES(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(DEPTH),
      "occupancy above depth")
   `ASSERT_IMPLIES(a_scan_bound, clock, reset, state_ff == pfdrc_pkg::ST_SCAN,
      cnt_ff < scan_len_ff, "scan past length")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != pfdrc_pkg::ST_IDLE,
      "idle after accept")
   `ASSERT_NEXT(a_add_nonempty, clock, reset, commit_fire && no_dup, occ_ff != '0,
      "empty after add")

endmodule
